// ----- rtl/snd_rf_pkg.sv -----
// ----------------------------------------------------------------------------
// Sound unit register file package
// Address map, register indexes, read/write masks and reset values.
// ----------------------------------------------------------------------------
package snd_rf_pkg;

	localparam int REG_COUNT_DEF  = 23;
	localparam int WAVE_BYTES_DEF = 16;

	localparam logic [15:0] REG_BASE  = 16'hFF10;
	localparam logic [15:0] WAVE_BASE = 16'hFF30;

	// register indexes relative to REG_BASE
	localparam logic [4:0] IDX_NR12 = 5'h02;
	localparam logic [4:0] IDX_NR14 = 5'h04;
	localparam logic [4:0] IDX_NR22 = 5'h07;
	localparam logic [4:0] IDX_NR24 = 5'h09;
	localparam logic [4:0] IDX_NR30 = 5'h0A;
	localparam logic [4:0] IDX_NR34 = 5'h0E;
	localparam logic [4:0] IDX_NR42 = 5'h11;
	localparam logic [4:0] IDX_NR44 = 5'h13;
	localparam logic [4:0] IDX_NR50 = 5'h14;
	localparam logic [4:0] IDX_NR51 = 5'h15;
	localparam logic [4:0] IDX_NR52 = 5'h16;

	localparam logic [7:0] PWR_FILL  = 8'h70;
	localparam logic [7:0] ENV_DAC   = 8'hF0;
	localparam logic [7:0] BYTE_ONES = 8'hFF;

	function automatic logic [7:0] rd_mask(input logic [4:0] idx);
		logic [7:0] m;
		case (idx)
			5'h00: m = 8'h7F;
			5'h01: m = 8'hC0;
			5'h02: m = 8'hFF;
			5'h03: m = 8'h00;
			5'h04: m = 8'h40;
			5'h05: m = 8'h00;
			5'h06: m = 8'hC0;
			5'h07: m = 8'hFF;
			5'h08: m = 8'h00;
			5'h09: m = 8'h40;
			5'h0A: m = 8'h80;
			5'h0B: m = 8'h00;
			5'h0C: m = 8'h60;
			5'h0D: m = 8'h00;
			5'h0E: m = 8'h40;
			5'h0F: m = 8'h00;
			5'h10: m = 8'h00;
			5'h11: m = 8'hFF;
			5'h12: m = 8'hFF;
			5'h13: m = 8'h40;
			5'h14: m = 8'hFF;
			5'h15: m = 8'hFF;
			5'h16: m = 8'h8F;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] wr_mask(input logic [4:0] idx);
		logic [7:0] m;
		case (idx)
			5'h00: m = 8'h7F;
			5'h05: m = 8'h00;
			5'h0A: m = 8'h80;
			5'h0C: m = 8'h60;
			5'h0F: m = 8'h00;
			5'h10: m = 8'h3F;
			5'h16: m = 8'h80;
			default: m = 8'hFF;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] reg_rst_val(input logic [4:0] idx);
		logic [7:0] v;
		case (idx)
			IDX_NR50: v = 8'h77;
			IDX_NR51: v = 8'hF3;
			default:  v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/snd_rf_ram.sv -----
// ----------------------------------------------------------------------------
// Sound unit register file RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module snd_rf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/sound_unit_register_file.sv -----
// Flow: an accepted request moves to the execute state and its result is registered
// once any earlier result held by out_stall has gone; no new request is taken until
// then. Each request reads its register or wave RAM entry when accepted and writes back
// when it completes. Reset: flags and valid bits clear at once; unwritten entries read
// reset values (registers: zero after a power-off; wave: 00 or FF), so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Sound unit register file
// Bus side of a four-channel sound unit: registers, wave RAM, DAC and enables.
// ----------------------------------------------------------------------------
module sound_unit_register_file #(
	parameter int REG_COUNT  = snd_rf_pkg::REG_COUNT_DEF,
	parameter int WAVE_BYTES = snd_rf_pkg::WAVE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data
);

	import snd_rf_pkg::*;

	localparam int REG_AW  = $clog2(REG_COUNT);
	localparam int WAVE_AW = $clog2(WAVE_BYTES);

	typedef enum logic {ST_IDLE, ST_EXEC} state_t;

	state_t              state_q;
	logic                func_s1;
	logic                reg_hit_s1;
	logic                wave_hit_s1;
	logic [REG_AW-1:0]   idx_s1;
	logic [WAVE_AW-1:0]  widx_s1;
	logic [7:0]          wdata_s1;
	logic                out_valid_q;
	logic [7:0]          read_data_q;
	logic                power_q;
	logic                cleared_q;
	logic [3:0]          dac_q;
	logic [3:0]          en_q;
	logic [REG_COUNT-1:0]  reg_vld_q;
	logic [WAVE_BYTES-1:0] wave_vld_q;

	// decode of the incoming request
	logic [15:0]        reg_off;
	logic [15:0]        wave_off;
	logic               reg_hit;
	logic               wave_hit;
	logic               accept;

	assign reg_off  = address - REG_BASE;
	assign wave_off = address - WAVE_BASE;
	assign reg_hit  = (address >= REG_BASE) && (reg_off < 16'(REG_COUNT));
	assign wave_hit = (address >= WAVE_BASE) && (wave_off < 16'(WAVE_BYTES));
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// RAMs
	logic               reg_we;
	logic               wave_we;
	logic [7:0]         reg_rdata;
	logic [7:0]         wave_rdata;
	logic [7:0]         reg_new;

	snd_rf_ram #(
		.WIDTH (8),
		.DEPTH (REG_COUNT)
	) u_reg_ram (
		.clk   (clk),
		.we    (reg_we),
		.waddr (idx_s1),
		.wdata (reg_new),
		.re    (accept && reg_hit),
		.raddr (reg_off[REG_AW-1:0]),
		.rdata (reg_rdata)
	);

	snd_rf_ram #(
		.WIDTH (8),
		.DEPTH (WAVE_BYTES)
	) u_wave_ram (
		.clk   (clk),
		.we    (wave_we),
		.waddr (widx_s1),
		.wdata (wdata_s1),
		.re    (accept && wave_hit),
		.raddr (wave_off[WAVE_AW-1:0]),
		.rdata (wave_rdata)
	);

	// execute stage
	logic               done;
	logic               is_power;
	logic               reg_write;
	logic [4:0]         idx5;
	logic [7:0]         wmask;
	logic [7:0]         rmask;
	logic [7:0]         reg_old;
	logic [7:0]         wave_old;
	logic [7:0]         rd_val;
	logic               pwr_d;
	logic               clr_d;
	logic [3:0]         dac_d;
	logic [3:0]         en_d;

	assign idx5      = 5'(idx_s1);
	assign done      = (state_q == ST_EXEC) && !(out_valid_q && out_stall);
	assign is_power  = reg_hit_s1 && (idx5 == IDX_NR52);
	assign reg_write = done && func_s1 && reg_hit_s1 && !is_power && power_q;
	assign reg_we    = reg_write;
	assign wave_we   = done && func_s1 && wave_hit_s1;
	assign wmask     = wr_mask(idx5);
	assign rmask     = rd_mask(idx5);

	// register entries not yet written hold the reset value, or zero once powered off; wave entries read 00 or FF
	assign reg_old  = (reg_hit_s1 && reg_vld_q[idx_s1]) ? reg_rdata :
	                  (cleared_q ? 8'h00 : reg_rst_val(idx5));
	assign wave_old = (wave_hit_s1 && wave_vld_q[widx_s1]) ? wave_rdata :
	                  (widx_s1[0] ? BYTE_ONES : 8'h00);
	assign reg_new  = (reg_old & ~wmask) | (wdata_s1 & wmask);

	always_comb begin
		if (wave_hit_s1) begin
			rd_val = (power_q && en_q[2]) ? BYTE_ONES : wave_old;
		end else if (is_power) begin
			rd_val = PWR_FILL | {power_q, 3'b000, en_q};
		end else if (reg_hit_s1) begin
			rd_val = (reg_old & rmask) | ~rmask;
		end else begin
			rd_val = BYTE_ONES;
		end
	end

	always_comb begin
		pwr_d = power_q;
		clr_d = 1'b0;
		dac_d = dac_q;
		en_d  = en_q;
		if (done && func_s1 && is_power) begin
			if (!wdata_s1[7] && power_q) begin
				clr_d = 1'b1;
				en_d  = 4'b0000;
			end
			pwr_d = wdata_s1[7];
		end else if (reg_write) begin
			unique case (idx5)
				IDX_NR12: dac_d[0] = |(reg_new & ENV_DAC);
				IDX_NR22: dac_d[1] = |(reg_new & ENV_DAC);
				IDX_NR30: dac_d[2] = reg_new[7];
				IDX_NR42: dac_d[3] = |(reg_new & ENV_DAC);
				IDX_NR14: if (wdata_s1[7] && dac_q[0]) en_d[0] = 1'b1;
				IDX_NR24: if (wdata_s1[7] && dac_q[1]) en_d[1] = 1'b1;
				IDX_NR34: if (wdata_s1[7] && dac_q[2]) en_d[2] = 1'b1;
				IDX_NR44: if (wdata_s1[7] && dac_q[3]) en_d[3] = 1'b1;
				default: ;
			endcase
			// a DAC switched off drops its channel
			en_d = en_d & dac_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			func_s1     <= 1'b0;
			reg_hit_s1  <= 1'b0;
			wave_hit_s1 <= 1'b0;
			idx_s1      <= '0;
			widx_s1     <= '0;
			wdata_s1    <= '0;
			out_valid_q <= 1'b0;
			read_data_q <= '0;
			power_q     <= 1'b0;
			cleared_q   <= 1'b0;
			dac_q       <= '0;
			en_q        <= '0;
			reg_vld_q   <= '0;
			wave_vld_q  <= '0;
		end else begin
			if (!out_stall && !done) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						func_s1     <= func;
						reg_hit_s1  <= reg_hit;
						wave_hit_s1 <= wave_hit;
						idx_s1      <= reg_off[REG_AW-1:0];
						widx_s1     <= wave_off[WAVE_AW-1:0];
						wdata_s1    <= write_data;
						state_q     <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (done) begin
						out_valid_q <= 1'b1;
						read_data_q <= func_s1 ? 8'h00 : rd_val;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			power_q <= pwr_d;
			dac_q   <= dac_d;
			en_q    <= en_d;
			if (clr_d) begin
				reg_vld_q <= '0;
				cleared_q <= 1'b1;
			end else if (reg_we) begin
				reg_vld_q[idx_s1] <= 1'b1;
			end
			if (wave_we) begin
				wave_vld_q[widx_s1] <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule

// ----- verif/sound_unit_register_file_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sound unit register file testbench
// A directed table of bus requests is replayed first, followed by weighted
// random requests: power up and down, DAC and trigger pairs, register, wave RAM
// and out-of-range traffic. Results are checked against a shadow model of the
// registers, wave RAM, DAC and enable flags, or against the byte a typed directed
// row gives. Requests arrive in bursts, and the result side stalls on changing patterns with one long hold-off.
// ----------------------------------------------------------------------------
module sound_unit_register_file_tb;

	import snd_rf_pkg::*;

	localparam int          ITEM_TARGET     = 1900;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam int          DRAIN_CYCLES    = 10;
	localparam int          CYCLE_LIMIT     = 400000;
	localparam int          DIR_ROWS        = 26;

	// slots with no register behind them
	localparam logic [4:0]  IDX_GAP_NR1     = 5'h05;
	localparam logic [4:0]  IDX_GAP_NR3     = 5'h0F;

	localparam logic [15:0] ADDR_NR12 = REG_BASE + 16'(IDX_NR12);
	localparam logic [15:0] ADDR_NR14 = REG_BASE + 16'(IDX_NR14);
	localparam logic [15:0] ADDR_NR30 = REG_BASE + 16'(IDX_NR30);
	localparam logic [15:0] ADDR_NR34 = REG_BASE + 16'(IDX_NR34);
	localparam logic [15:0] ADDR_NR50 = REG_BASE + 16'(IDX_NR50);
	localparam logic [15:0] ADDR_NR52 = REG_BASE + 16'(IDX_NR52);
	localparam logic [15:0] REG_END   = REG_BASE + 16'(REG_COUNT_DEF);
	localparam logic [15:0] WAVE_END  = WAVE_BASE + 16'(WAVE_BYTES_DEF);

	localparam logic [0:22][7:0] READABLE_BITS = {
		8'h7F, 8'hC0, 8'hFF, 8'h00, 8'h40, 8'h00,
		8'hC0, 8'hFF, 8'h00, 8'h40,
		8'h80, 8'h00, 8'h60, 8'h00, 8'h40, 8'h00,
		8'h00, 8'hFF, 8'hFF, 8'h40,
		8'hFF, 8'hFF, 8'h8F
	};
	localparam logic [0:22][7:0] WRITABLE_BITS = {
		8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
		8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'h80, 8'hFF, 8'h60, 8'hFF, 8'hFF, 8'h00,
		8'h3F, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'h80
	};

	typedef enum bit {ACC_READ = 1'b0, ACC_WRITE = 1'b1} access_kind_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_pattern_t;

	typedef struct {
		access_kind_t kind;
		logic [15:0]  addr;
		logic [7:0]   data;
		bit           typed;
		logic [7:0]   want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;

	// shadow state
	logic [7:0]  shadow_regs [REG_COUNT_DEF];
	logic [7:0]  shadow_wave [WAVE_BYTES_DEF];
	logic [3:0]  dac_on;
	logic [3:0]  ch_enabled;

	logic [7:0]  pending_read_data [$];
	dir_row_t    directed_rows [DIR_ROWS];

	int          cycle_count = 0;
	int          mismatches = 0;
	int          requests_sent = 0;
	int          reads_sent = 0;
	int          writes_sent = 0;
	int          power_offs = 0;
	int          channel_starts = 0;
	int          burst_left = 0;
	bit          hold_off_pending = 1'b0;

	sound_unit_register_file i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.address    (address),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_read_data.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Applies one bus access to the shadow state; returns the byte the bus gives back.
	function automatic logic [7:0] sound_access_result(access_kind_t kind, logic [15:0] addr,
			logic [7:0] data);
		logic [4:0] idx;
		logic [7:0] v;
		logic [7:0] msk;
		bit         pwr;
		int         dac_ch;
		int         trig_ch;
		idx = 5'(addr - REG_BASE);
		pwr = shadow_regs[IDX_NR52][7];
		if (addr >= WAVE_BASE && addr < WAVE_END) begin
			if (kind == ACC_WRITE) begin
				shadow_wave[addr[3:0]] = data;
				return 8'h00;
			end
			return (pwr && ch_enabled[2]) ? BYTE_ONES : shadow_wave[addr[3:0]];
		end
		if (addr < REG_BASE || addr >= REG_END)
			return (kind == ACC_WRITE) ? 8'h00 : BYTE_ONES;
		if (kind == ACC_READ) begin
			msk = READABLE_BITS[idx];
			v = shadow_regs[idx];
			if (idx == IDX_NR52)
				v = {v[7], 3'b000, ch_enabled};
			return (v & msk) | ~msk;
		end
		if (idx == IDX_NR52) begin
			// power-down wipes registers and enables, DAC flags survive
			if (!data[7] && pwr) begin
				foreach (shadow_regs[i])
					shadow_regs[i] = 8'h00;
				ch_enabled = 4'h0;
				power_offs++;
			end
			shadow_regs[IDX_NR52] = {data[7], 3'b000, ch_enabled};
			return 8'h00;
		end
		if (!pwr)
			return 8'h00;
		msk = WRITABLE_BITS[idx];
		shadow_regs[idx] = (shadow_regs[idx] & ~msk) | (data & msk);
		dac_ch = -1;
		trig_ch = -1;
		case (idx)
			IDX_NR12: dac_ch = 0;
			IDX_NR22: dac_ch = 1;
			IDX_NR30: dac_ch = 2;
			IDX_NR42: dac_ch = 3;
			IDX_NR14: trig_ch = 0;
			IDX_NR24: trig_ch = 1;
			IDX_NR34: trig_ch = 2;
			IDX_NR44: trig_ch = 3;
			default: ;
		endcase
		if (dac_ch >= 0) begin
			dac_on[dac_ch] = (idx == IDX_NR30) ? shadow_regs[idx][7]
				: |(shadow_regs[idx] & ENV_DAC);
			if (!dac_on[dac_ch])
				ch_enabled[dac_ch] = 1'b0;
		end
		if (trig_ch >= 0 && data[7] && dac_on[trig_ch]) begin
			ch_enabled[trig_ch] = 1'b1;
			channel_starts++;
		end
		return 8'h00;
	endfunction

	// Offers one request, holding it until accepted; typed rows override the shadow model.
	task automatic send_req(access_kind_t kind, logic [15:0] addr, logic [7:0] data,
			bit typed = 1'b0, logic [7:0] want = 8'h00);
		logic [7:0] predicted;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		in_valid   <= 1'b1;
		func       <= kind;
		address    <= addr;
		write_data <= data;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = sound_access_result(kind, addr, data);
		pending_read_data = {pending_read_data, (typed ? want : predicted)};
		burst_left--;
		requests_sent++;
		if (kind == ACC_WRITE)
			writes_sent++;
		else
			reads_sent++;
	endtask

	// result checker
	always @(posedge clk) begin
		logic [7:0] due;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_read_data.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("cycle %0d: result read_data=%02h with nothing outstanding",
						cycle_count, read_data);
			end else begin
				due = pending_read_data.pop_front();
				if (read_data !== due) begin
					mismatches++;
					if (mismatches <= 10)
						$display("cycle %0d: read_data expected %02h got %02h",
							cycle_count, due, read_data);
				end
			end
		end
	end

	// result side back-pressure
	initial begin
		int             mode_left;
		stall_pattern_t pattern;
		mode_left = 0;
		pattern = STALL_NONE;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				pattern = stall_pattern_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 160);
			end
			mode_left--;
			case (pattern)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= ~out_stall;
			endcase
		end
	end

	initial begin
		int          pick;
		int          ch;
		bit          hold_off_done;
		logic [4:0]  dac_idx;
		logic [4:0]  trig_idx;
		logic [7:0]  d;
		logic [15:0] a;
		access_kind_t kind;

		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		func       <= ACC_READ;
		address    <= 16'h0000;
		write_data <= 8'h00;
		hold_off_done = 1'b0;

		foreach (shadow_regs[i])
			shadow_regs[i] = 8'h00;
		shadow_regs[IDX_NR50] = 8'h77;
		shadow_regs[IDX_NR51] = 8'hF3;
		foreach (shadow_wave[i])
			shadow_wave[i] = (i % 2) ? 8'hFF : 8'h00;
		dac_on = 4'h0;
		ch_enabled = 4'h0;

		directed_rows = '{
			'{ACC_READ,  ADDR_NR52,               8'h00, 1'b1, 8'h70},
			'{ACC_READ,  ADDR_NR50,               8'h00, 1'b1, 8'h77},
			'{ACC_READ,  WAVE_BASE,               8'h00, 1'b1, 8'h00},
			'{ACC_READ,  WAVE_END - 16'd1,        8'hFF, 1'b1, 8'hFF},
			'{ACC_READ,  16'h0000,                8'h00, 1'b1, 8'hFF},
			'{ACC_READ,  16'hFFFF,                8'hFF, 1'b1, 8'hFF},
			'{ACC_READ,  REG_BASE - 16'd1,        8'h00, 1'b1, 8'hFF},
			'{ACC_READ,  REG_END,                 8'h00, 1'b1, 8'hFF},
			// unit is off: register write dropped, wave RAM write kept
			'{ACC_WRITE, ADDR_NR12,               8'hF0, 1'b1, 8'h00},
			'{ACC_READ,  ADDR_NR12,               8'h00, 1'b1, 8'h00},
			'{ACC_WRITE, WAVE_BASE + 16'd1,       8'h5A, 1'b1, 8'h00},
			'{ACC_READ,  WAVE_BASE + 16'd1,       8'h00, 1'b1, 8'h5A},
			'{ACC_WRITE, ADDR_NR52,               8'hFF, 1'b1, 8'h00},
			'{ACC_READ,  ADDR_NR52,               8'h00, 1'b1, 8'hF0},
			'{ACC_WRITE, ADDR_NR12,               8'hF3, 1'b0, 8'h00},
			'{ACC_WRITE, ADDR_NR14,               8'h87, 1'b0, 8'h00},
			'{ACC_WRITE, ADDR_NR30,               8'h80, 1'b0, 8'h00},
			'{ACC_WRITE, ADDR_NR34,               8'hC0, 1'b0, 8'h00},
			'{ACC_READ,  ADDR_NR52,               8'h00, 1'b0, 8'h00},
			// channel 3 running: wave RAM hidden
			'{ACC_READ,  WAVE_BASE + 16'd1,       8'h00, 1'b0, 8'h00},
			'{ACC_WRITE, ADDR_NR12,               8'h07, 1'b0, 8'h00},
			'{ACC_READ,  REG_BASE + 16'(IDX_GAP_NR1), 8'h00, 1'b1, 8'hFF},
			'{ACC_READ,  REG_BASE + 16'(IDX_GAP_NR3), 8'h00, 1'b1, 8'hFF},
			'{ACC_WRITE, ADDR_NR52,               8'h7F, 1'b1, 8'h00},
			'{ACC_READ,  ADDR_NR52,               8'h00, 1'b1, 8'h70},
			'{ACC_READ,  ADDR_NR50,               8'h00, 1'b1, 8'h00}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_req(directed_rows[r].kind, directed_rows[r].addr, directed_rows[r].data,
				directed_rows[r].typed, directed_rows[r].want);

		while (requests_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			d = 8'($urandom_range(0, 255));
			kind = access_kind_t'($urandom_range(0, 1));
			if (pick < 12) begin
				// power up, arm a DAC, trigger, then look at the status
				ch = $urandom_range(0, 3);
				case (ch)
					0:       begin dac_idx = IDX_NR12; trig_idx = IDX_NR14; end
					1:       begin dac_idx = IDX_NR22; trig_idx = IDX_NR24; end
					2:       begin dac_idx = IDX_NR30; trig_idx = IDX_NR34; end
					default: begin dac_idx = IDX_NR42; trig_idx = IDX_NR44; end
				endcase
				send_req(ACC_WRITE, ADDR_NR52, d | 8'h80);
				send_req(ACC_WRITE, REG_BASE + 16'(dac_idx), 8'($urandom_range(0, 255)));
				send_req(ACC_WRITE, REG_BASE + 16'(trig_idx), 8'($urandom_range(128, 255)));
				send_req(ACC_READ, ADDR_NR52, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1))
					send_req(ACC_READ, WAVE_BASE + 16'($urandom_range(0, 15)), d);
			end else if (pick < 17) begin
				send_req(ACC_WRITE, ADDR_NR52, d);
			end else if (pick < 50) begin
				send_req(kind, REG_BASE + 16'($urandom_range(0, REG_COUNT_DEF - 1)), d);
			end else if (pick < 75) begin
				send_req(kind, WAVE_BASE + 16'($urandom_range(0, WAVE_BYTES_DEF - 1)), d);
			end else if (pick < 87) begin
				send_req(kind, 16'($urandom_range(0, 65535)), d);
			end else begin
				case ($urandom_range(0, 5))
					0:       a = REG_BASE - 16'd1;
					1:       a = REG_END;
					2:       a = WAVE_BASE - 16'd1;
					3:       a = WAVE_END;
					4:       a = 16'h0000;
					default: a = 16'hFFFF;
				endcase
				send_req(kind, a, d);
			end
			// one long stall on the result side while requests keep coming
			if (!hold_off_done && requests_sent >= 600) begin
				hold_off_pending = 1'b1;
				hold_off_done = 1'b1;
			end
		end
		in_valid <= 1'b0;

		while (pending_read_data.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests (%0d reads, %0d writes) over %0d cycles.",
			requests_sent, reads_sent, writes_sent, cycle_count);
		$display("Power-downs: %0d, channel starts: %0d, result hold-off of %0d cycles.",
			power_offs, channel_starts, HOLD_OFF_CYCLES);
		if (mismatches == 0 && pending_read_data.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
